[rtl/gsd_pkg.sv]
// Package for the greedy sequence decoder.
// Holds the item structs, the field widths, the result kind codes and the FSM state type.
// It has no dependencies.
package gsd_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned IDX_W   = 13;

  localparam logic KIND_SYMBOL  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_class;
    logic                      last_step;
  } in_t;

  typedef struct packed {
    logic                      result_kind;
    logic [IDX_W-1:0]          symbol_index;
    logic signed [SCORE_W-1:0] symbol_score;
    logic signed [SCORE_W-1:0] average_score;
    logic                      last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    S_ACC = 3'b001,
    S_DIV = 3'b010,
    S_SUM = 3'b100
  } state_e;

endpackage

[rtl/gsd_div.sv]
// Iterative restoring divider for the sequence average, one quotient bit per cycle.
// Signed dividend, unsigned divisor, quotient truncated toward zero; uses gsd_pkg.
// A zero divisor gives a zero quotient.
module gsd_div import gsd_pkg::*; #(
  parameter int unsigned SUM_W = 25,
  parameter int unsigned CNT_W = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SUM_W-1:0]   dividend_i,
  input  logic [CNT_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic signed [SCORE_W-1:0] quot_o
);

  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic [SUM_W-1:0]  quo_signed;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    neg_d  = neg_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, dsr_q};
    if (start_i) begin
      dsr_d = divisor_i;
      rem_d = '0;
      if (divisor_i == '0) begin
        neg_d  = 1'b0;
        quo_d  = '0;
        done_d = 1'b1;
      end else begin
        neg_d  = dividend_i[SUM_W-1];
        quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
        busy_d = 1'b1;
        iter_d = ITER_W'(SUM_W);
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      iter_d = iter_q - ITER_W'(1);
      if (iter_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // The mean of 16-bit scores always fits 16 bits, so the low bits carry it.
  assign quo_signed = neg_q ? (SUM_W'(0) - quo_q) : quo_q;
  assign quot_o     = SCORE_W'(quo_signed);
  assign done_o     = done_q;

endmodule

[rtl/greedy_sequence_decode.sv]
// Greedy sequence decoder: per-timestep arg-max, duplicate removal, sequence average.
// Top level; uses gsd_pkg and the gsd_div divider.
// Throughput: one score item per cycle while in the accumulate state and the output register is free or being drained.
// A kept symbol result is registered and appears in the cycle after the item that closes its timestep.
// A sequence-end item blocks input while the bit-serial divider runs and until the summary
// is loaded; with no symbol kept the divide is skipped. Reset is asynchronous, no clear pass.
module greedy_sequence_decode import gsd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned MAX_STEPS   = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_item_o
);

  localparam int unsigned POS_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned CLS_W = $clog2(MAX_CLASSES);
  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned SUM_W = 17 + $clog2(MAX_STEPS);

  state_e                    state_q, state_d;
  logic                      rmdup_q;
  logic signed [SCORE_W-1:0] best_val_q;
  logic [CLS_W-1:0]          best_cls_q;
  logic [POS_W-1:0]          pos_q;
  logic [CLS_W-1:0]          prev_q;
  logic                      have_prev_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      out_valid_q;
  out_t                      out_q;

  logic                      slot_free;
  logic                      in_ok;
  logic                      in_range;
  logic                      take;
  logic signed [SCORE_W-1:0] b_val;
  logic [CLS_W-1:0]          b_cls;
  logic [POS_W-1:0]          pos_inc;
  logic                      drop;
  logic                      keep_add;
  logic signed [SUM_W-1:0]   sum_upd;
  logic [CNT_W-1:0]          cnt_upd;
  logic                      seq_end;
  logic                      div_done;
  logic signed [SCORE_W-1:0] div_quot;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_ACC) && slot_free;
  assign in_ok      = in_valid_i && in_ready_o;
  assign seq_end    = in_ok && in_item_i.last_class && in_item_i.last_step;

  always_comb begin
    in_range = pos_q < POS_W'(MAX_CLASSES);
    take     = in_range && ((pos_q == '0) || (in_item_i.score > best_val_q));
    b_val    = take ? in_item_i.score : best_val_q;
    b_cls    = take ? pos_q[CLS_W-1:0] : best_cls_q;
    pos_inc  = in_range ? pos_q + POS_W'(1) : pos_q;
    drop     = rmdup_q && have_prev_q && (b_cls == prev_q);
    keep_add = !drop && (cnt_q < CNT_W'(MAX_STEPS));
    sum_upd  = keep_add ? sum_q + SUM_W'(b_val) : sum_q;
    cnt_upd  = keep_add ? cnt_q + CNT_W'(1) : cnt_q;
  end

  gsd_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (seq_end),
    .dividend_i (sum_upd),
    .divisor_i  (cnt_upd),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_ACC: if (seq_end) state_d = S_DIV;
      S_DIV: if (div_done) state_d = S_SUM;
      S_SUM: if (slot_free) state_d = S_ACC;
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      rmdup_q     <= 1'b1;
      best_val_q  <= '0;
      best_cls_q  <= '0;
      pos_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rmdup_q <= cfg_wdata_i;
      end
      if (in_ok) begin
        if (!in_item_i.last_class) begin
          best_val_q <= b_val;
          best_cls_q <= b_cls;
          pos_q      <= pos_inc;
        end else begin
          best_val_q <= '0;
          best_cls_q <= '0;
          pos_q      <= '0;
          if (in_item_i.last_step) begin
            prev_q      <= '0;
            have_prev_q <= 1'b0;
            sum_q       <= '0;
            cnt_q       <= '0;
          end else begin
            prev_q      <= b_cls;
            have_prev_q <= 1'b1;
            sum_q       <= sum_upd;
            cnt_q       <= cnt_upd;
          end
        end
      end
    end
  end

  // Output register: a kept symbol loads on its closing item, the summary once the
  // divider is done and the register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_ok && in_item_i.last_class && !drop) ||
                 (state_q == S_SUM && slot_free)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ok && in_item_i.last_class && !drop) begin
      out_q.result_kind   <= KIND_SYMBOL;
      out_q.symbol_index  <= IDX_W'(b_cls);
      out_q.symbol_score  <= b_val;
      out_q.average_score <= '0;
      out_q.last_of_run   <= !in_item_i.last_step;
    end else if (state_q == S_SUM && slot_free) begin
      out_q.result_kind   <= KIND_SUMMARY;
      out_q.symbol_index  <= '0;
      out_q.symbol_score  <= '0;
      out_q.average_score <= div_quot;
      out_q.last_of_run   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_summary_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && slot_free) |=>
      (out_valid_q && out_q.result_kind == KIND_SUMMARY && state_q == S_ACC))
    else $error("summary item not loaded when leaving the summary state");

  a_seq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_end |=> (cnt_q == '0 && sum_q == '0 && !have_prev_q && state_q == S_DIV))
    else $error("sequence state not cleared at sequence end");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_STEPS))
    else $error("kept count exceeds its limit");
`endif

endmodule
